// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the lottery scheduler modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LTS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lts: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LTS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lts: assertion failed");

`endif

// ===== design/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, codes and width helpers for the lottery ticket scheduler.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int MAX_PROCS_DEF   = 16;
	localparam int TICKET_BITS_DEF = 16;

	localparam int COUNT_W     = 16;
	localparam int RND_W       = 31;
	localparam int SLOT_W      = 4;
	localparam int TOTAL_OUT_W = 20;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic mod_start;
		logic walk_start;
		logic walk_step;
		logic win_capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic draw_go;
		logic mod_done;
		logic walk_hit;
	} sts_t;

	function automatic int cnt_w(input int tb);
		return (tb < COUNT_W) ? tb : COUNT_W;
	endfunction

	function automatic int idx_w(input int mp);
		return $clog2(mp);
	endfunction

	function automatic int su_w(input int mp);
		return $clog2(mp + 1);
	endfunction

	function automatic int tot_w(input int mp, input int tb);
		return su_w(mp) + cnt_w(tb);
	endfunction

endpackage

// ===== design/lts_mod.sv =====
// ----------------------------------------------------------------------------
// lts_mod
// Restoring serial modulo: one dividend bit per cycle, over all RND_W dividend bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lts_mod
	import lts_pkg::*;
#(
	parameter int MAX_PROCS   = MAX_PROCS_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [RND_W-1:0]                         dividend,
	input  logic [tot_w(MAX_PROCS, TICKET_BITS)-1:0] divisor,
	output logic [tot_w(MAX_PROCS, TICKET_BITS)-1:0] rem,
	output logic                                     done
);

	localparam int TOT_W = tot_w(MAX_PROCS, TICKET_BITS);
	localparam int CNT_B = $clog2(RND_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_B-1:0] cnt_q;
	logic [TOT_W-1:0] rem_q;
	logic [RND_W-1:0] div_q;
	logic [TOT_W:0]   trial;
	logic [TOT_W:0]   diff;
	logic [TOT_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, div_q[RND_W-1]};
		diff  = trial - {1'b0, divisor};
		if (trial >= {1'b0, divisor}) begin
			rem_next = diff[TOT_W-1:0];
		end else begin
			rem_next = trial[TOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_B'(1);
				if (cnt_q == CNT_B'(RND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			div_q <= {div_q[RND_W-2:0], 1'b0};
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

	`LTS_ASSERT_IMP(a_start_idle, start, !busy_q)

endmodule

// ===== design/lts_dp.sv =====
// ----------------------------------------------------------------------------
// lts_dp
// Datapath: ticket table, totals, modulo unit, cumulative walk, result regs.
// ----------------------------------------------------------------------------
module lts_dp
	import lts_pkg::*;
#(
	parameter int MAX_PROCS   = MAX_PROCS_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   opcode,
	input  logic [COUNT_W-1:0]     ticket_count,
	input  logic [RND_W-1:0]       random_value,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic [1:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [COUNT_W-1:0]     tickets_before,
	output logic [COUNT_W-1:0]     tickets_after,
	output logic [TOTAL_OUT_W-1:0] total_after,
	output logic [TOTAL_OUT_W-1:0] winning_number,
	output logic                   slot_emptied
);

	localparam int CNT_W = cnt_w(TICKET_BITS);
	localparam int IDX_W = idx_w(MAX_PROCS);
	localparam int SU_W  = su_w(MAX_PROCS);
	localparam int TOT_W = tot_w(MAX_PROCS, TICKET_BITS);
	localparam logic [COUNT_W:0] CNT_MAX = ((COUNT_W + 1)'(1) << CNT_W) - (COUNT_W + 1)'(1);

	logic               opcode_q;
	logic [COUNT_W-1:0] count_q;
	logic [RND_W-1:0]   rnd_q;
	logic [SU_W-1:0]    slots_used_q;
	logic [TOT_W-1:0]   total_q;

	logic [CNT_W-1:0]   mem_q [MAX_PROCS];
	logic [CNT_W-1:0]   rd_data_s1;
	logic [IDX_W-1:0]   rd_addr;

	logic [IDX_W-1:0]   walk_idx_q;
	logic [TOT_W-1:0]   sum_q;
	logic [TOT_W-1:0]   sum_next;
	logic [TOT_W-1:0]   win_q;
	logic [IDX_W-1:0]   win_idx_q;
	logic [CNT_W-1:0]   before_q;

	logic [TOT_W-1:0]   mod_rem;
	logic               mod_done;

	logic [CNT_W-1:0]   cnt_sat;
	logic [CNT_W-1:0]   after_v;
	status_t            status_d;
	logic [IDX_W-1:0]   slot_d;
	logic [CNT_W-1:0]   before_d;
	logic [CNT_W-1:0]   after_d;
	logic [TOT_W-1:0]   win_d;
	logic               empt_d;
	logic [TOT_W-1:0]   total_d;
	logic [SU_W-1:0]    su_d;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [CNT_W-1:0]   wr_data;

	status_t                  status_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [COUNT_W-1:0]       before_out_q;
	logic [COUNT_W-1:0]       after_out_q;
	logic [TOTAL_OUT_W-1:0]   total_out_q;
	logic [TOTAL_OUT_W-1:0]   win_out_q;
	logic                     empt_q;

	lts_mod #(
		.MAX_PROCS   (MAX_PROCS),
		.TICKET_BITS (TICKET_BITS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (rnd_q),
		.divisor  (total_q),
		.rem      (mod_rem),
		.done     (mod_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opcode_q <= opcode;
			count_q  <= ticket_count;
			rnd_q    <= random_value;
		end
	end

	assign rd_addr  = cmd.walk_start ? '0 : walk_idx_q + IDX_W'(1);
	assign sum_next = sum_q + TOT_W'(rd_data_s1);

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem_q[rd_addr];
		if (wr_en && cmd.commit) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			walk_idx_q <= '0;
			sum_q      <= '0;
			win_q      <= mod_rem + TOT_W'(1);
		end else if (cmd.walk_step) begin
			walk_idx_q <= walk_idx_q + IDX_W'(1);
			sum_q      <= sum_next;
		end
		if (cmd.win_capture) begin
			win_idx_q <= walk_idx_q;
			before_q  <= rd_data_s1;
		end
	end

	always_comb begin
		if ({1'b0, count_q} > CNT_MAX) begin
			cnt_sat = CNT_MAX[CNT_W-1:0];
		end else begin
			cnt_sat = count_q[CNT_W-1:0];
		end
		after_v  = (before_q != '0) ? before_q - CNT_W'(1) : '0;
		status_d = ST_OK;
		slot_d   = '0;
		before_d = '0;
		after_d  = '0;
		win_d    = '0;
		empt_d   = 1'b0;
		total_d  = total_q;
		su_d     = slots_used_q;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		if (opcode_q == OP_ADD) begin
			if (count_q == '0) begin
				status_d = ST_ZERO;
			end else if (slots_used_q == SU_W'(MAX_PROCS)) begin
				status_d = ST_FULL;
			end else begin
				wr_en   = 1'b1;
				wr_addr = slots_used_q[IDX_W-1:0];
				wr_data = cnt_sat;
				su_d    = slots_used_q + SU_W'(1);
				total_d = total_q + TOT_W'(cnt_sat);
				slot_d  = slots_used_q[IDX_W-1:0];
				after_d = cnt_sat;
			end
		end else if (total_q == '0) begin
			status_d = ST_EMPTY;
		end else begin
			wr_en    = 1'b1;
			wr_addr  = win_idx_q;
			wr_data  = after_v;
			total_d  = total_q - TOT_W'(1);
			slot_d   = win_idx_q;
			before_d = before_q;
			after_d  = after_v;
			win_d    = win_q;
			empt_d   = (after_v == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= '0;
			total_q      <= '0;
		end else if (cmd.commit) begin
			slots_used_q <= su_d;
			total_q      <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q     <= status_d;
			slot_q       <= SLOT_W'(slot_d);
			before_out_q <= COUNT_W'(before_d);
			after_out_q  <= COUNT_W'(after_d);
			total_out_q  <= TOTAL_OUT_W'(total_d);
			win_out_q    <= TOTAL_OUT_W'(win_d);
			empt_q       <= empt_d;
		end
	end

	assign sts.draw_go  = (opcode_q == OP_DRAW) && (total_q != '0);
	assign sts.mod_done = mod_done;
	assign sts.walk_hit = (sum_next >= win_q);

	assign status         = status_q;
	assign slot           = slot_q;
	assign tickets_before = before_out_q;
	assign tickets_after  = after_out_q;
	assign total_after    = total_out_q;
	assign winning_number = win_out_q;
	assign slot_emptied   = empt_q;

endmodule

// ===== design/lts_ctrl.sv =====
// ----------------------------------------------------------------------------
// lts_ctrl
// Controller: sequences capture, modulo, table walk and result commit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lts_ctrl
	import lts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_DIVIDE = 5'b00100,
		S_WALK   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.draw_go) begin
					cmd.mod_start = 1'b1;
					state_d       = S_DIVIDE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIVIDE: begin
				if (sts.mod_done) begin
					cmd.walk_start = 1'b1;
					state_d        = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.walk_hit) begin
					cmd.win_capture = 1'b1;
					state_d         = S_FINISH;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	`LTS_ASSERT_IMP(a_commit_free, cmd.commit, !out_valid_q || !out_stall)
	`LTS_ASSERT_NXT(a_accept_decode, in_valid && !in_stall, state_q == S_DECODE)
	`LTS_ASSERT_IMP(a_done_in_divide, sts.mod_done, state_q == S_DIVIDE)

endmodule

// ===== design/lottery_ticket_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// lottery_ticket_scheduler_core
// Lottery scheduler over a table of process slots, one result per item.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with opcode, ticket_count, random_value.
// An add (opcode 0) appends a slot; a draw (opcode 1) picks a winner as the
// first slot whose running ticket sum reaches (random_value mod total) + 1,
// then takes one ticket from it.
// Output channel: out_valid / out_stall, one result beat per input beat.
// An add or a rejected item passes from capture through decode to the
// commit of its result. A draw first runs the serial modulo unit, one
// dividend bit per cycle, then walks the table one slot per cycle over
// the table's single read port, up to the winning slot.
// One item is in flight at a time; in_stall is high after the input beat
// until its result is loaded into the output register.
// The output register holds a result while out_stall is high; the next item
// is still taken and runs until it needs that register.
// Reset clears the slot count and the total; the table needs no clearing,
// since only values from slots below the slot count are ever used.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler_core
	import lts_pkg::*;
#(
	parameter int MAX_PROCS   = MAX_PROCS_DEF,
	parameter int TICKET_BITS = TICKET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [COUNT_W-1:0]     ticket_count,
	input  logic [RND_W-1:0]       random_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [COUNT_W-1:0]     tickets_before,
	output logic [COUNT_W-1:0]     tickets_after,
	output logic [TOTAL_OUT_W-1:0] total_after,
	output logic [TOTAL_OUT_W-1:0] winning_number,
	output logic                   slot_emptied
);

	cmd_t cmd;
	sts_t sts;

	lts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lts_dp #(
		.MAX_PROCS   (MAX_PROCS),
		.TICKET_BITS (TICKET_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.opcode         (opcode),
		.ticket_count   (ticket_count),
		.random_value   (random_value),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.slot           (slot),
		.tickets_before (tickets_before),
		.tickets_after  (tickets_after),
		.total_after    (total_after),
		.winning_number (winning_number),
		.slot_emptied   (slot_emptied)
	);

endmodule
